[design/rqi_pkg.sv]
// shared types, widths and register indexes for the ray / quad intersection block
package rqi_pkg;

    localparam int COMP_W  = 21;
    localparam int VEC_W   = 63;
    localparam int CFG_W   = 63;
    localparam int IDX_W   = 3;
    localparam int DOT_W   = 56;   // sum of three 21x32 products
    localparam int NUM_W   = 58;   // offset term minus dot
    localparam int T_W     = 31;

    localparam logic [IDX_W-1:0] REG_UNIT_NORMAL   = 3'd0;
    localparam logic [IDX_W-1:0] REG_PLANE_OFFSET  = 3'd1;
    localparam logic [IDX_W-1:0] REG_SCALED_NORMAL = 3'd2;
    localparam logic [IDX_W-1:0] REG_CORNER_POINT  = 3'd3;
    localparam logic [IDX_W-1:0] REG_EDGE_FIRST    = 3'd4;
    localparam logic [IDX_W-1:0] REG_EDGE_SECOND   = 3'd5;
    localparam logic [IDX_W-1:0] REG_MIN_DISTANCE  = 3'd6;
    localparam logic [IDX_W-1:0] REG_MATERIAL_ID   = 3'd7;

    typedef logic signed [COMP_W-1:0] comp_t;

    // per-item control carried down the pipeline
    typedef struct packed {
        logic valid;
        logic back_face;
        logic live;      // still a candidate hit
        logic neg;       // quotient sign negative
    } ctl_t;

    function automatic comp_t comp_of(input logic [VEC_W-1:0] p, input int k);
        comp_t c;
        c = p[k*COMP_W +: COMP_W];
        return c;
    endfunction

endpackage

[design/ray_quad_intersect.sv]
// top level of the ray / parallelogram intersection pipeline
//
// one ray is accepted at each rising edge with start high and busy low; busy
// is always low, so a ray may enter every cycle and rays stream back to back.
// the user must write configuration through cfg_we / cfg_index / cfg_data only
// while no ray is in flight (not enforced); writes take effect at once.
// each ray gives exactly one result: done is high for one cycle with hit,
// back_face, hit_t, point, coordinates, normal and material on the ports.
// a ray passes the plane dots, the 32-stage restoring divider (one quotient
// bit per stage: 19 integer bits, a guard bit and 12 fraction bits) and the
// hit point and planar coordinate math, ending in the result register.
// throughput is one ray per cycle.
// reset clears every valid bit in flight and returns the registers to their
// reset values (min_distance 4, all others zero).
// the receiver cannot stall: results must be taken when done is high.
module ray_quad_intersect
    import rqi_pkg::*;
#(
    parameter int FRAC_BITS = 12
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 cfg_we,
    input  logic [IDX_W-1:0]     cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic signed [31:0]   origin_x,
    input  logic signed [31:0]   origin_y,
    input  logic signed [31:0]   origin_z,
    input  logic signed [31:0]   dir_x,
    input  logic signed [31:0]   dir_y,
    input  logic signed [31:0]   dir_z,
    input  logic [T_W-1:0]       max_t,
    output logic                 done,
    output logic                 hit,
    output logic                 back_face,
    output logic [T_W-1:0]       hit_t,
    output logic signed [31:0]   point_x,
    output logic signed [31:0]   point_y,
    output logic signed [31:0]   point_z,
    output logic [12:0]          coord_u,
    output logic [12:0]          coord_v,
    output logic [VEC_W-1:0]     normal_out,
    output logic [15:0]          material_out
);

    localparam int QW  = T_W - FRAC_BITS + 1 + FRAC_BITS;  // integer guard plus fraction
    localparam int DLY = 2 + QW;
    localparam int DW  = NUM_W + FRAC_BITS;

    logic [VEC_W-1:0]    nrm_reg, w_reg, q_reg, u_reg, v_reg;
    logic signed [31:0]  off_reg;
    logic [T_W-1:0]      mind_reg;
    logic [15:0]         mat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nrm_reg <= '0; off_reg <= '0; w_reg <= '0; q_reg <= '0;
            u_reg <= '0; v_reg <= '0; mind_reg <= T_W'(4); mat_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_UNIT_NORMAL:   nrm_reg  <= cfg_data;
                REG_PLANE_OFFSET:  off_reg  <= cfg_data[31:0];
                REG_SCALED_NORMAL: w_reg    <= cfg_data;
                REG_CORNER_POINT:  q_reg    <= cfg_data;
                REG_EDGE_FIRST:    u_reg    <= cfg_data;
                REG_EDGE_SECOND:   v_reg    <= cfg_data;
                REG_MIN_DISTANCE:  mind_reg <= cfg_data[T_W-1:0];
                REG_MATERIAL_ID:   mat_reg  <= cfg_data[15:0];
                default:           ;
            endcase
        end
    end

    assign busy = 1'b0;

    logic                accept;
    logic signed [31:0]  org [3];
    logic signed [31:0]  dir [3];
    assign accept = start && !busy;
    assign org[0] = origin_x; assign org[1] = origin_y; assign org[2] = origin_z;
    assign dir[0] = dir_x;    assign dir[1] = dir_y;    assign dir[2] = dir_z;

    // ray data delayed alongside the dot stage and divider
    logic signed [31:0]  od_reg [DLY][3];
    logic signed [31:0]  dd_reg [DLY][3];
    logic [T_W-1:0]      md_reg [DLY];
    ctl_t                cq_reg [QW];

    always_ff @(posedge clk)
    begin
        od_reg[0] <= org; dd_reg[0] <= dir; md_reg[0] <= max_t;
        for (int s = 1; s < DLY; s++)
        begin
            od_reg[s] <= od_reg[s-1];
            dd_reg[s] <= dd_reg[s-1];
            md_reg[s] <= md_reg[s-1];
        end
    end

    ctl_t               ctl0;
    logic [NUM_W-1:0]   num_mag, den_mag;

    rqi_dot_stage #(.FRAC_BITS(FRAC_BITS)) u_dot (
        .clk(clk), .rst_n(rst_n), .in_valid(accept), .nrm(nrm_reg),
        .offset(off_reg), .org(org), .dir(dir),
        .ctl(ctl0), .num_mag(num_mag), .den_mag(den_mag)
    );

    logic             qv;
    logic             dov;
    logic [QW-1:0]    quo;

    // the divider takes num << F; its bits above the low QW seed the remainder
    rqi_divider #(.NW(DW), .QW(QW)) u_div (
        .clk(clk), .rst_n(rst_n), .in_valid(ctl0.valid),
        .dividend({num_mag, {FRAC_BITS{1'b0}}}),
        .divisor(DW'(den_mag)),
        .out_valid(qv), .overflow(dov), .quotient(quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < QW; s++)
                cq_reg[s] <= '0;
        end
        else
        begin
            cq_reg[0] <= ctl0;
            for (int s = 1; s < QW; s++)
                cq_reg[s] <= cq_reg[s-1];
        end
    end

    ctl_t             cdiv;
    logic [T_W-1:0]   tq;
    logic             overflow;
    logic             in_t;
    assign overflow = |quo[QW-1:T_W] || dov;
    assign tq       = quo[T_W-1:0];
    assign in_t     = !overflow && !(cq_reg[QW-1].neg && tq != '0)
                      && tq >= mind_reg && tq <= md_reg[DLY-1];

    always_comb
    begin
        cdiv       = cq_reg[QW-1];
        cdiv.valid = qv;
        cdiv.live  = cq_reg[QW-1].live && in_t;
    end

    rqi_hit_stage #(.FRAC_BITS(FRAC_BITS)) u_hit (
        .clk(clk), .rst_n(rst_n), .ctl_in(cdiv), .t_in(tq),
        .org(od_reg[DLY-1]), .dir(dd_reg[DLY-1]),
        .w_vec(w_reg), .q_vec(q_reg), .u_vec(u_reg), .v_vec(v_reg),
        .nrm(nrm_reg), .material(mat_reg),
        .done(done), .hit(hit), .back_face(back_face), .hit_t(hit_t),
        .point_x(point_x), .point_y(point_y), .point_z(point_z),
        .coord_u(coord_u), .coord_v(coord_v),
        .normal_out(normal_out), .material_out(material_out)
    );

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !hit |-> hit_t == '0 && material_out == '0)
        else $error("miss carries payload");
    a_hit_done: assert property (@(posedge clk) disable iff (!rst_n)
        hit |-> done)
        else $error("hit without result strobe");
    a_t_range: assert property (@(posedge clk) disable iff (!rst_n)
        hit |-> coord_u <= 13'd4096 || FRAC_BITS != 12)
        else $error("coordinate out of range");

endmodule

[design/rqi_divider.sv]
// pipelined restoring divider, one quotient bit per stage
module rqi_divider
    import rqi_pkg::*;
#(
    parameter int NW = 70,
    parameter int QW = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [NW-1:0]     dividend,
    input  logic [NW-1:0]     divisor,
    output logic              out_valid,
    output logic              overflow,
    output logic [QW-1:0]     quotient
);

    // dividend bits above the low QW start as the partial remainder; if they
    // already reach the divisor the quotient does not fit in QW bits
    logic                 v_reg   [QW];
    logic                 ov_reg  [QW];
    logic [NW-1:0]        rem_reg [QW];
    logic [NW-1:0]        num_reg [QW];
    logic [NW-1:0]        den_reg [QW];
    logic [QW-1:0]        quo_reg [QW];

    for (genvar s = 0; s < QW; s++)
    begin : g_stage
        logic            v_in;
        logic            ov_in;
        logic [NW-1:0]   rem_in;
        logic [NW-1:0]   num_in;
        logic [NW-1:0]   den_in;
        logic [QW-1:0]   quo_in;
        logic [NW:0]     trial;
        logic [NW:0]     diff;

        if (s == 0)
        begin : g_first
            assign v_in   = in_valid;
            assign rem_in = NW'(dividend[NW-1:QW]);
            assign num_in = {dividend[QW-1:0], {(NW-QW){1'b0}}};
            assign den_in = divisor;
            assign quo_in = '0;
            assign ov_in  = (rem_in >= den_in);
        end
        else
        begin : g_next
            assign v_in   = v_reg[s-1];
            assign rem_in = rem_reg[s-1];
            assign num_in = num_reg[s-1];
            assign den_in = den_reg[s-1];
            assign quo_in = quo_reg[s-1];
            assign ov_in  = ov_reg[s-1];
        end

        always_comb
        begin
            trial = {rem_in, num_in[NW-1]};
            diff  = trial - {1'b0, den_in};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[s] <= 1'b0;
            else
                v_reg[s] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (!diff[NW])
                rem_reg[s] <= diff[NW-1:0];
            else
                rem_reg[s] <= trial[NW-1:0];
            num_reg[s] <= {num_in[NW-2:0], 1'b0};
            den_reg[s] <= den_in;
            quo_reg[s] <= {quo_in[QW-2:0], ~diff[NW]};
            ov_reg[s]  <= ov_in;
        end
    end

    assign out_valid = v_reg[QW-1];
    assign overflow  = ov_reg[QW-1];
    assign quotient  = quo_reg[QW-1];

endmodule

[design/rqi_dot_stage.sv]
// plane dots: denominator, numerator and their magnitudes
module rqi_dot_stage
    import rqi_pkg::*;
#(
    parameter int FRAC_BITS = 12
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic [VEC_W-1:0]        nrm,
    input  logic signed [31:0]      offset,
    input  logic signed [31:0]      org [3],
    input  logic signed [31:0]      dir [3],
    output ctl_t                    ctl,
    output logic [NUM_W-1:0]        num_mag,
    output logic [NUM_W-1:0]        den_mag
);

    logic signed [52:0]    pd_reg [3];
    logic signed [52:0]    po_reg [3];
    logic signed [31:0]    off_reg;
    logic                  v1_reg;
    logic signed [NUM_W-1:0] den, num;
    ctl_t                  ctl_reg;
    logic [NUM_W-1:0]      num_reg, den_reg;

    // stage 1: products
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            pd_reg[k] <= comp_of(nrm, k) * dir[k];
            po_reg[k] <= comp_of(nrm, k) * org[k];
        end
        off_reg <= offset;
    end

    always_comb
    begin
        den = NUM_W'(pd_reg[0]) + NUM_W'(pd_reg[1]) + NUM_W'(pd_reg[2]);
        num = (NUM_W'(off_reg) <<< FRAC_BITS) - NUM_W'(po_reg[0])
              - NUM_W'(po_reg[1]) - NUM_W'(po_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            ctl_reg <= '0;
        end
        else
        begin
            v1_reg            <= in_valid;
            ctl_reg.valid     <= v1_reg;
            ctl_reg.back_face <= (den > 0);
            ctl_reg.live      <= (den != 0);
            ctl_reg.neg       <= num[NUM_W-1] ^ den[NUM_W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num[NUM_W-1] ? NUM_W'(-num) : num;
        den_reg <= den[NUM_W-1] ? NUM_W'(-den) : den;
    end

    assign ctl     = ctl_reg;
    assign num_mag = num_reg;
    assign den_mag = den_reg;

endmodule

[design/rqi_hit_stage.sv]
// hit point, planar coordinates and final result register
module rqi_hit_stage
    import rqi_pkg::*;
#(
    parameter int FRAC_BITS = 12
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  ctl_t                    ctl_in,
    input  logic [T_W-1:0]          t_in,
    input  logic signed [31:0]      org [3],
    input  logic signed [31:0]      dir [3],
    input  logic [VEC_W-1:0]        w_vec,
    input  logic [VEC_W-1:0]        q_vec,
    input  logic [VEC_W-1:0]        u_vec,
    input  logic [VEC_W-1:0]        v_vec,
    input  logic [VEC_W-1:0]        nrm,
    input  logic [15:0]             material,
    output logic                    done,
    output logic                    hit,
    output logic                    back_face,
    output logic [T_W-1:0]          hit_t,
    output logic signed [31:0]      point_x,
    output logic signed [31:0]      point_y,
    output logic signed [31:0]      point_z,
    output logic [12:0]             coord_u,
    output logic [12:0]             coord_v,
    output logic [VEC_W-1:0]        normal_out,
    output logic [15:0]             material_out
);

    localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;

    // a: dir*t products
    ctl_t                   ca_reg, cb_reg, cc_reg, cd_reg, ce_reg;
    logic signed [63:0]     dt_reg [3];
    logic signed [31:0]     oa_reg [3];
    logic [T_W-1:0]         ta_reg, tb_reg, tc_reg, td_reg, te_reg;
    // b: saturated point and p - q
    logic signed [31:0]     pt_reg [3], ptc_reg [3], ptd_reg [3], pte_reg [3];
    logic signed [33:0]     pv_reg [3];
    // c: cross product terms
    logic signed [63:0]     ca1_reg [3], ca2_reg [3], cb1_reg [3], cb2_reg [3];
    // d: floored cross components
    logic signed [53:0]     xa_reg [3], xb_reg [3];
    // e: dot with w
    logic signed [63:0]     da_reg [3], db_reg [3];

    logic signed [63:0]     pfull [3];
    logic signed [63:0]     pvx [3];
    logic signed [63:0]     sa, sb, al, be;
    logic                   in_range;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            pfull[k] = 64'(oa_reg[k]) + (dt_reg[k] >>> FRAC_BITS);
            pvx[k]   = 64'(pv_reg[k]);
        end
        sa = da_reg[0] + da_reg[1] + da_reg[2];
        sb = db_reg[0] + db_reg[1] + db_reg[2];
        al = sa >>> FRAC_BITS;
        be = sb >>> FRAC_BITS;
        in_range = (al >= 0) && (al <= ONE) && (be >= 0) && (be <= ONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ca_reg <= '0; cb_reg <= '0; cc_reg <= '0;
            cd_reg <= '0; ce_reg <= '0;
        end
        else
        begin
            ca_reg <= ctl_in;
            cb_reg <= ca_reg;
            cc_reg <= cb_reg;
            cd_reg <= cc_reg;
            ce_reg <= cd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            dt_reg[k] <= dir[k] * $signed({1'b0, t_in});
            oa_reg[k] <= org[k];
            if (pfull[k] > 64'sd2147483647)
                pt_reg[k] <= 32'sh7fffffff;
            else if (pfull[k] < -64'sd2147483648)
                pt_reg[k] <= 32'sh80000000;
            else
                pt_reg[k] <= pfull[k][31:0];
            pv_reg[k] <= 34'(pfull[k] > 64'sd2147483647 ? 64'sd2147483647 :
                             pfull[k] < -64'sd2147483648 ? -64'sd2147483648 : pfull[k])
                         - 34'(comp_of(q_vec, k));
            ptc_reg[k] <= pt_reg[k];
            ptd_reg[k] <= ptc_reg[k];
            pte_reg[k] <= ptd_reg[k];
        end
        // alpha cross: pv x v, beta cross: u x pv
        ca1_reg[0] <= pvx[1] * comp_of(v_vec, 2);  ca2_reg[0] <= pvx[2] * comp_of(v_vec, 1);
        ca1_reg[1] <= pvx[2] * comp_of(v_vec, 0);  ca2_reg[1] <= pvx[0] * comp_of(v_vec, 2);
        ca1_reg[2] <= pvx[0] * comp_of(v_vec, 1);  ca2_reg[2] <= pvx[1] * comp_of(v_vec, 0);
        cb1_reg[0] <= comp_of(u_vec, 1) * pvx[2];  cb2_reg[0] <= comp_of(u_vec, 2) * pvx[1];
        cb1_reg[1] <= comp_of(u_vec, 2) * pvx[0];  cb2_reg[1] <= comp_of(u_vec, 0) * pvx[2];
        cb1_reg[2] <= comp_of(u_vec, 0) * pvx[1];  cb2_reg[2] <= comp_of(u_vec, 1) * pvx[0];
        for (int k = 0; k < 3; k++)
        begin
            xa_reg[k] <= 54'((ca1_reg[k] - ca2_reg[k]) >>> FRAC_BITS);
            xb_reg[k] <= 54'((cb1_reg[k] - cb2_reg[k]) >>> FRAC_BITS);
            da_reg[k] <= 64'(comp_of(w_vec, k)) * 64'(xa_reg[k]);
            db_reg[k] <= 64'(comp_of(w_vec, k)) * 64'(xb_reg[k]);
        end
        ta_reg <= t_in; tb_reg <= ta_reg; tc_reg <= tb_reg;
        td_reg <= tc_reg; te_reg <= td_reg;
    end

    // result register
    logic                done_reg, hit_reg, bf_reg;
    logic [T_W-1:0]      t_reg;
    logic signed [31:0]  px_reg, py_reg, pz_reg;
    logic [12:0]         u_reg, v_reg;
    logic [VEC_W-1:0]    n_reg;
    logic [15:0]         m_reg;
    logic                take;

    assign take = ce_reg.valid && ce_reg.live && in_range;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            hit_reg  <= 1'b0;
            bf_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= ce_reg.valid;
            hit_reg  <= take;
            bf_reg   <= ce_reg.back_face;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg  <= take ? te_reg : '0;
        px_reg <= take ? pte_reg[0] : '0;
        py_reg <= take ? pte_reg[1] : '0;
        pz_reg <= take ? pte_reg[2] : '0;
        u_reg  <= take ? al[12:0] : '0;
        v_reg  <= take ? be[12:0] : '0;
        n_reg  <= take ? nrm : '0;
        m_reg  <= take ? material : '0;
    end

    assign done         = done_reg;
    assign hit          = hit_reg;
    assign back_face    = bf_reg;
    assign hit_t        = t_reg;
    assign point_x      = px_reg;
    assign point_y      = py_reg;
    assign point_z      = pz_reg;
    assign coord_u      = u_reg;
    assign coord_v      = v_reg;
    assign normal_out   = n_reg;
    assign material_out = m_reg;

endmodule
